@@ hw/rtl/qvr_pkg.sv @@
// Shared types, widths and register codes for the quaternion vector rotator.
package qvr_pkg;

  localparam int QW  = 18;  // quaternion component, Q2.16
  localparam int QEW = 19;  // component after an exact negation
  localparam int MW  = 38;  // rotation matrix entry at 2^-32 scale
  localparam int PW  = 32;  // position coordinate, Q16.16
  localparam int HIW = 54;  // entry times signed upper half of a coordinate
  localparam int LOW = 55;  // entry times unsigned lower half of a coordinate
  localparam int AW  = 56;  // sum of three upper-half products
  localparam int BW  = 57;  // sum of three lower-half products
  localparam int CW  = 57;  // combined sum at 2^-32 scale
  localparam int SW  = 41;  // combined sum at 2^-16 scale, before saturation
  localparam int CFG_IW = 3;

  localparam logic signed [QW-1:0] QUAT_W_RESET = 18'sd65536;

  typedef logic signed [QW-1:0]  quat_t;
  typedef logic signed [QEW-1:0] quat_ext_t;
  typedef logic signed [MW-1:0]  mat_t;
  typedef logic signed [PW-1:0]  pos_t;

  typedef mat_t     mat_row_t [3];
  typedef mat_row_t mat3_t    [3];
  typedef pos_t     vec3_t    [3];

  typedef enum logic [CFG_IW-1:0] {
    REG_QUAT_W  = 3'd0,
    REG_QUAT_X  = 3'd1,
    REG_QUAT_Y  = 3'd2,
    REG_QUAT_Z  = 3'd3,
    REG_REVERSE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    quat_t w;
    quat_t x;
    quat_t y;
    quat_t z;
    logic  rev;
  } quat_cfg_t;

  // Load enables of the datapath stages behind the input register.
  typedef struct packed {
    logic ld2;
    logic ld3;
    logic ld4;
    logic ld5;
  } pipe_ctl_t;

endpackage

@@ hw/rtl/qvr_matrix.sv @@
// Expands the configured quaternion into the 3x3 rotation matrix in two register stages.
module qvr_matrix import qvr_pkg::*; (
  input  logic      clk,
  input  quat_cfg_t cfg_nxt,
  output mat3_t     mat
);

  quat_ext_t w, x, y, z;
  mat_t ww_nxt, wx_nxt, wy_nxt, wz_nxt, xx_nxt, xy_nxt, xz_nxt, yy_nxt, yz_nxt, zz_nxt;
  mat_t ww_r, wx_r, wy_r, wz_r, xx_r, xy_r, xz_r, yy_r, yz_r, zz_r;
  mat3_t mat_nxt, mat_r;

  // The products are taken from the incoming register values, so the matrix
  // is settled in the cycle after a write lands.
  always_comb begin
    w = QEW'(cfg_nxt.w);
    x = cfg_nxt.rev ? -QEW'(cfg_nxt.x) : QEW'(cfg_nxt.x);
    y = cfg_nxt.rev ? -QEW'(cfg_nxt.y) : QEW'(cfg_nxt.y);
    z = cfg_nxt.rev ? -QEW'(cfg_nxt.z) : QEW'(cfg_nxt.z);
    ww_nxt = w * w;
    wx_nxt = w * x;
    wy_nxt = w * y;
    wz_nxt = w * z;
    xx_nxt = x * x;
    xy_nxt = x * y;
    xz_nxt = x * z;
    yy_nxt = y * y;
    yz_nxt = y * z;
    zz_nxt = z * z;
  end

  always_ff @(posedge clk) begin
    ww_r <= ww_nxt;
    wx_r <= wx_nxt;
    wy_r <= wy_nxt;
    wz_r <= wz_nxt;
    xx_r <= xx_nxt;
    xy_r <= xy_nxt;
    xz_r <= xz_nxt;
    yy_r <= yy_nxt;
    yz_r <= yz_nxt;
    zz_r <= zz_nxt;
  end

  always_comb begin
    mat_nxt[0][0] = ww_r + xx_r - yy_r - zz_r;
    mat_nxt[0][1] = (xy_r - wz_r) <<< 1;
    mat_nxt[0][2] = (xz_r + wy_r) <<< 1;
    mat_nxt[1][0] = (xy_r + wz_r) <<< 1;
    mat_nxt[1][1] = ww_r - xx_r + yy_r - zz_r;
    mat_nxt[1][2] = (yz_r - wx_r) <<< 1;
    mat_nxt[2][0] = (xz_r - wy_r) <<< 1;
    mat_nxt[2][1] = (yz_r + wx_r) <<< 1;
    mat_nxt[2][2] = ww_r - xx_r - yy_r + zz_r;
  end

  always_ff @(posedge clk) begin
    mat_r <= mat_nxt;
  end

  assign mat = mat_r;

endmodule

@@ hw/rtl/qvr_row.sv @@
// One matrix row times the position vector: split products, sums, combine, saturate.
module qvr_row import qvr_pkg::*; (
  input  logic      clk,
  input  pipe_ctl_t ctl,
  input  mat_row_t  row,
  input  vec3_t     pos,
  output pos_t      rot
);

  logic signed [HIW-1:0] hi_nxt [3];
  logic signed [LOW-1:0] lo_nxt [3];
  logic signed [HIW-1:0] hi_r [3];
  logic signed [LOW-1:0] lo_r [3];
  logic signed [AW-1:0]  a_nxt, a_r;
  logic signed [BW-1:0]  b_nxt, b_r;
  logic signed [CW-1:0]  c_nxt, c_r;
  logic signed [SW-1:0]  s;
  pos_t                  rot_nxt, rot_r;

  // Each coordinate is split into a signed upper half and an unsigned lower
  // half so that no multiplier grows past 38 by 17 bits.
  always_comb begin
    logic signed [15:0] ph;
    logic signed [16:0] pl;
    for (int i = 0; i < 3; i++) begin
      ph = $signed(pos[i][31:16]);
      pl = $signed({1'b0, pos[i][15:0]});
      hi_nxt[i] = row[i] * ph;
      lo_nxt[i] = row[i] * pl;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign a_nxt = AW'(hi_r[0]) + AW'(hi_r[1]) + AW'(hi_r[2]);
  assign b_nxt = BW'(lo_r[0]) + BW'(lo_r[1]) + BW'(lo_r[2]);

  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
  end

  // Floor of the lower sum keeps the overall result a floor at 2^-32.
  assign c_nxt = CW'(a_r) + (CW'(b_r) >>> 16);

  always_ff @(posedge clk) begin
    if (ctl.ld4) begin
      c_r <= c_nxt;
    end
  end

  always_comb begin
    s = SW'(c_r >>> 16);
    if (s[SW-1:PW-1] == '0 || s[SW-1:PW-1] == '1) begin
      rot_nxt = s[PW-1:0];
    end else if (s[SW-1]) begin
      rot_nxt = {1'b1, {(PW-1){1'b0}}};
    end else begin
      rot_nxt = {1'b0, {(PW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld5) begin
      rot_r <= rot_nxt;
    end
  end

  assign rot = rot_r;

endmodule

@@ hw/rtl/quaternion_vector_rotate_top.sv @@
// Top level of the quaternion vector rotator: config registers, stage control, three rows.
//
// Rotates streamed 3D positions (signed Q16.16) by a quaternion held in
// configuration registers (signed Q2.16), through the equivalent 3x3 matrix.
// Input requests arrive on in_tvalid/in_tready/in_tdata, results leave on
// out_tvalid/out_tready/out_tdata; both carry x, y, z from the lowest bits up.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high and indexes beyond the reverse flag are ignored.
// Registers must be written only while no request is in flight; the user ensures
// this, the block does not enforce it. A request may follow in the very next cycle.
// Throughput is one request per cycle while out_tready does not stall the output.
// Five register stages stand between the ports (input, split products, row sums,
// combine, saturate).
// A stalled out_tready holds the output and the stages behind it fill up;
// in_tready drops only when every stage holds a request, so nothing is lost.
// Reset empties the pipeline and loads the identity quaternion, forward mode.
module quaternion_vector_rotate_top import qvr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [3*PW-1:0]   in_tdata,   // pos_x, pos_y, pos_z
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [3*PW-1:0]   out_tdata,  // rot_x, rot_y, rot_z
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [QW-1:0]     cfg_data
);

  quat_cfg_t         cfg_r, cfg_nxt;
  mat3_t             mat;
  logic [3*PW-1:0]   pos_r;
  vec3_t             pos;
  vec3_t             rot;
  logic [4:0]        vld_r, vld_nxt;
  logic [4:0]        rdy;
  pipe_ctl_t         ctl;
  logic              in_acc, out_acc;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (!rst_n) begin
      cfg_nxt.w   = QUAT_W_RESET;
      cfg_nxt.x   = '0;
      cfg_nxt.y   = '0;
      cfg_nxt.z   = '0;
      cfg_nxt.rev = 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_QUAT_W:  cfg_nxt.w   = $signed(cfg_data);
        REG_QUAT_X:  cfg_nxt.x   = $signed(cfg_data);
        REG_QUAT_Y:  cfg_nxt.y   = $signed(cfg_data);
        REG_QUAT_Z:  cfg_nxt.z   = $signed(cfg_data);
        REG_REVERSE: cfg_nxt.rev = cfg_data[0];
        default:     cfg_nxt     = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cfg_r <= cfg_nxt;
  end

  qvr_matrix u_matrix (
    .clk     (clk),
    .cfg_nxt (cfg_nxt),
    .mat     (mat)
  );

  // A stage takes new data when it is empty or its contents move on.
  always_comb begin
    rdy[4] = !vld_r[4] || out_tready;
    for (int k = 3; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt[0] = rdy[0] ? in_tvalid : vld_r[0];
    for (int k = 1; k < 5; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
    ctl.ld2 = rdy[1] && vld_r[0];
    ctl.ld3 = rdy[2] && vld_r[1];
    ctl.ld4 = rdy[3] && vld_r[2];
    ctl.ld5 = rdy[4] && vld_r[3];
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[4];
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pos_r <= in_tdata;
    end
  end

  assign pos[0] = pos_r[PW-1:0];
  assign pos[1] = pos_r[2*PW-1:PW];
  assign pos[2] = pos_r[3*PW-1:2*PW];

  for (genvar g = 0; g < 3; g++) begin : g_row
    qvr_row u_row (
      .clk (clk),
      .ctl (ctl),
      .row (mat[g]),
      .pos (pos),
      .rot (rot[g])
    );
  end

  assign out_tdata = {rot[2], rot[1], rot[0]};

  // Requests in flight change only by what the two channels move.
  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> $countones(vld_r) ==
             $past($countones(vld_r)) + $past(32'(in_acc)) - $past(32'(out_acc)))
    else $error("request count in the pipeline is not conserved");

  a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[0] && !rdy[0]) |=> vld_r[0] && $stable(pos_r))
    else $error("stalled input stage lost or changed its request");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> vld_r == '0)
    else $error("pipeline not empty after reset");

endmodule
